@@ rtl/core/tkti_pkg.sv @@
// ----------------------------------------------------------------------------
// tkti_pkg
// Shared types, constants and the type K lookup table for the thermocouple
// table interpolator.
// ----------------------------------------------------------------------------
package tkti_pkg;

    // default sizing of the table walk
    localparam int DEF_TABLE_POINTS     = 51;
    localparam int DEF_DEGREES_PER_STEP = 10;

    // table geometry
    localparam int TAB_DEPTH = 51;
    localparam int TAB_IDX_W = 6;
    localparam int V_W       = 15;

    // shared divider widths
    localparam int DIV_DVD_W = 32;
    localparam int DIV_DSR_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

    // configuration register fields
    localparam int OFFSET_W = 21;
    localparam int GAIN_W   = 16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

    // configuration register byte addresses
    typedef enum logic [2:0] {
        REG_OFFSET = 3'h0,
        REG_GAIN   = 3'h4
    } tkti_reg_addr_t;

    // stream field widths
    localparam int MEAS_W = 23;
    localparam int TEMP_OUT_W = 16;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset_uv;
        logic [GAIN_W-1:0]   gain_q8;
    } tkti_cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DSR_W-1:0] divisor;
    } tkti_div_req_t;

    typedef struct packed {
        logic                 done;
        logic                 busy;
        logic [DIV_DVD_W-1:0] quotient;
    } tkti_div_rsp_t;

    // type K emf in microvolts, one point every step from 0 C
    function automatic logic [V_W-1:0] tkti_tab(input logic [TAB_IDX_W-1:0] idx);
        logic [V_W-1:0] val;
        unique case (idx)
            6'd0:  val = 15'd0;
            6'd1:  val = 15'd397;
            6'd2:  val = 15'd798;
            6'd3:  val = 15'd1203;
            6'd4:  val = 15'd1612;
            6'd5:  val = 15'd2023;
            6'd6:  val = 15'd2436;
            6'd7:  val = 15'd2851;
            6'd8:  val = 15'd3267;
            6'd9:  val = 15'd3682;
            6'd10: val = 15'd4096;
            6'd11: val = 15'd4509;
            6'd12: val = 15'd4920;
            6'd13: val = 15'd5328;
            6'd14: val = 15'd5735;
            6'd15: val = 15'd6138;
            6'd16: val = 15'd6540;
            6'd17: val = 15'd6941;
            6'd18: val = 15'd7340;
            6'd19: val = 15'd7739;
            6'd20: val = 15'd8138;
            6'd21: val = 15'd8539;
            6'd22: val = 15'd8940;
            6'd23: val = 15'd9343;
            6'd24: val = 15'd9747;
            6'd25: val = 15'd10153;
            6'd26: val = 15'd10561;
            6'd27: val = 15'd10971;
            6'd28: val = 15'd11382;
            6'd29: val = 15'd11795;
            6'd30: val = 15'd12209;
            6'd31: val = 15'd12624;
            6'd32: val = 15'd13040;
            6'd33: val = 15'd13457;
            6'd34: val = 15'd13874;
            6'd35: val = 15'd14293;
            6'd36: val = 15'd14713;
            6'd37: val = 15'd15133;
            6'd38: val = 15'd15554;
            6'd39: val = 15'd15975;
            6'd40: val = 15'd16397;
            6'd41: val = 15'd16820;
            6'd42: val = 15'd17243;
            6'd43: val = 15'd17667;
            6'd44: val = 15'd18091;
            6'd45: val = 15'd18516;
            6'd46: val = 15'd18941;
            6'd47: val = 15'd19366;
            6'd48: val = 15'd19792;
            6'd49: val = 15'd20218;
            6'd50: val = 15'd20644;
            default: val = 15'd20644;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/core/tkti_cfg.sv @@
// ----------------------------------------------------------------------------
// tkti_cfg
// Register file for the offset and gain registers behind the APB port.
// ----------------------------------------------------------------------------
module tkti_cfg
    import tkti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output tkti_cfg_t   cfg
);

    logic [OFFSET_W-1:0] offset_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic                wr_en;
    logic [2:0]          reg_addr;

    assign pready   = 1'b1;
    assign wr_en    = psel & penable & pwrite & pready;
    // word aligned register address
    assign reg_addr = {paddr[2], 2'b00};

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            gain_reg   <= GAIN_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_addr)
                REG_OFFSET: offset_reg <= pwdata[OFFSET_W-1:0];
                REG_GAIN:   gain_reg   <= pwdata[GAIN_W-1:0];
                default:    offset_reg <= offset_reg;
            endcase
        end
    end

    // read mux, offset sign extended
    always_comb
    begin
        unique case (reg_addr)
            REG_OFFSET: prdata = {{(32-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg};
            REG_GAIN:   prdata = {{(32-GAIN_W){1'b0}}, gain_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.offset_uv = offset_reg;
    assign cfg.gain_q8   = gain_reg;

endmodule

@@ rtl/core/tkti_div.sv @@
// ----------------------------------------------------------------------------
// tkti_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tkti_div
    import tkti_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  tkti_div_req_t req,
    output tkti_div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_DSR_W-1:0] dsr_reg, dsr_next;
    logic [DIV_DSR_W-1:0] rem_reg, rem_next;
    logic [DIV_DSR_W:0]   rem_shift;
    logic [DIV_DSR_W:0]   trial;
    logic                 fits;

    // one compare and subtract step
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DIV_DVD_W-1]};
        trial     = rem_shift - {1'b0, dsr_reg};
        fits      = (rem_shift >= {1'b0, dsr_reg});
    end

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DIV_DSR_W-1:0] : rem_shift[DIV_DSR_W-1:0];
            dvd_next = {dvd_reg[DIV_DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = dvd_reg;

endmodule

@@ rtl/core/tkti_seq.sv @@
// ----------------------------------------------------------------------------
// tkti_seq
// Sequencer: offset and gain removal, table search, interpolation and result register.
// ----------------------------------------------------------------------------
module tkti_seq
    import tkti_pkg::*;
#(
    parameter int TABLE_POINTS     = DEF_TABLE_POINTS,
    parameter int DEGREES_PER_STEP = DEF_DEGREES_PER_STEP
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tkti_cfg_t             cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MEAS_W-1:0]     in_meas,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TEMP_OUT_W-1:0] out_temp,
    output logic                  out_oor,
    output tkti_div_req_t         div_req,
    input  tkti_div_rsp_t         div_rsp
);

    localparam int NPTS     = (TABLE_POINTS < TAB_DEPTH) ? TABLE_POINTS : TAB_DEPTH;
    localparam int IDX_W    = $clog2(NPTS);
    localparam int STEP     = DEGREES_PER_STEP * 100;
    localparam int STEP_W   = $clog2(STEP + 1);
    localparam int PROD_W   = V_W + STEP_W;
    localparam int TEMP_RAW = IDX_W + STEP_W + 1;
    localparam int TEMP_W   = (TEMP_RAW > TEMP_OUT_W + 1) ? TEMP_RAW : TEMP_OUT_W + 1;
    localparam int SUM_W    = MEAS_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NPTS - 1);
    localparam logic [V_W-1:0]   V_LAST   = tkti_tab(TAB_IDX_W'(NPTS - 1));
    localparam logic [TEMP_W-1:0] MAX_CENTI =
        ((NPTS - 1) * STEP > 65535) ? TEMP_W'(65535) : TEMP_W'((NPTS - 1) * STEP);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV1,
        S_SEARCH,
        S_LOAD,
        S_MUL,
        S_DIV2,
        S_SUM,
        S_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic                    neg_reg, neg_next;
    logic [V_W-1:0]          v_reg, v_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        probe_reg, probe_next;
    logic [V_W-1:0]          diff_reg, diff_next;
    logic [V_W-1:0]          span_reg, span_next;
    logic [STEP_W-1:0]       frac_reg, frac_next;
    logic [TEMP_OUT_W-1:0]   temp_reg, temp_next;
    logic                    oor_reg, oor_next;
    logic                    out_valid_reg, out_valid_next;
    logic [TEMP_OUT_W-1:0]   out_temp_reg, out_temp_next;
    logic                    out_oor_reg, out_oor_next;

    logic [SUM_W-1:0]        sum_in;
    logic [SUM_W-1:0]        mag;
    logic [IDX_W-1:0]        cand;
    logic                    cand_ok;
    logic [V_W-1:0]          tab_lo;
    logic [V_W-1:0]          tab_hi;
    logic [PROD_W-1:0]       prod;
    logic [TEMP_W-1:0]       base;

    // offset added to the measured sample
    assign sum_in = {in_meas[MEAS_W-1], in_meas}
                  + {{(SUM_W-OFFSET_W){cfg.offset_uv[OFFSET_W-1]}}, cfg.offset_uv};
    assign mag    = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    // binary search probe
    assign cand    = idx_reg | probe_reg;
    assign cand_ok = ({1'b0, cand} < (IDX_W+1)'(NPTS))
                   && (tkti_tab(TAB_IDX_W'(cand)) <= v_reg);

    // segment ends
    assign tab_lo = tkti_tab(TAB_IDX_W'(idx_reg));
    assign tab_hi = tkti_tab(TAB_IDX_W'(TAB_IDX_W'(idx_reg) + TAB_IDX_W'(1)));

    // interpolation terms
    assign prod = PROD_W'(diff_reg) * PROD_W'(STEP);
    assign base = TEMP_W'(idx_reg) * TEMP_W'(STEP) + TEMP_W'(frac_reg);

    // divider requests
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {mag[DIV_DVD_W-9:0], 8'h00};
        div_req.divisor  = cfg.gain_q8;
        if (state_reg == S_PREP)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == S_MUL)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_DVD_W'(prod);
            div_req.divisor  = DIV_DSR_W'(span_reg);
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        neg_next       = neg_reg;
        v_next         = v_reg;
        idx_next       = idx_reg;
        probe_next     = probe_reg;
        diff_next      = diff_reg;
        span_next      = span_reg;
        frac_next      = frac_reg;
        temp_next      = temp_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg;
        out_temp_next  = out_temp_reg;
        out_oor_next   = out_oor_reg;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sum_next = sum_in;
                    if (cfg.gain_q8 == '0)
                    begin
                        temp_next  = '0;
                        oor_next   = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                neg_next   = sum_reg[SUM_W-1];
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    if ((neg_reg && div_rsp.quotient != '0)
                        || (!neg_reg && div_rsp.quotient > DIV_DVD_W'(V_LAST)))
                    begin
                        temp_next  = '0;
                        oor_next   = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        v_next     = neg_reg ? '0 : div_rsp.quotient[V_W-1:0];
                        idx_next   = '0;
                        probe_next = {1'b1, {(IDX_W-1){1'b0}}};
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (cand_ok)
                begin
                    idx_next = cand;
                end
                probe_next = probe_reg >> 1;
                if (probe_reg[0])
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    frac_next  = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    diff_next  = v_reg - tab_lo;
                    span_next  = tab_hi - tab_lo;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    frac_next  = div_rsp.quotient[STEP_W-1:0];
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                temp_next  = (base > TEMP_W'(65535)) ? '1 : base[TEMP_OUT_W-1:0];
                oor_next   = 1'b0;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_temp_next  = temp_reg;
                    out_oor_next   = oor_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        neg_reg      <= neg_next;
        v_reg        <= v_next;
        idx_reg      <= idx_next;
        probe_reg    <= probe_next;
        diff_reg     <= diff_next;
        span_reg     <= span_next;
        frac_reg     <= frac_next;
        temp_reg     <= temp_next;
        oor_reg      <= oor_next;
        out_temp_reg <= out_temp_next;
        out_oor_reg  <= out_oor_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_temp  = out_temp_reg;
    assign out_oor   = out_oor_reg;

`ifndef ASSERT_OFF
    // divider only finishes while the sequencer waits for it
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV1 || state_reg == S_DIV2))
        else $error("divider finished outside a wait state");

    // an accepted request closes the input until its result is built
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still open after a request was taken");

    // out of range results carry zero temperature
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_oor) |-> (out_temp == '0))
        else $error("out of range result with nonzero temperature");

    // in range results never pass the last table point
    a_temp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_oor) |-> (TEMP_W'(out_temp) <= MAX_CENTI))
        else $error("temperature beyond the table span");
`endif

endmodule

@@ rtl/core/thermocouple_k_table_interpolate.sv @@
// ----------------------------------------------------------------------------
// thermocouple_k_table_interpolate
// Type K thermocouple linearizer: removes the amplifier offset and gain,
// then interpolates in a 10 degree type K table, result in 0.01 C.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata[22:0] measured_uv
//  m_axis    out        tdata[15:0] temperature_centi_c, tuser[0] out_of_range
//  apb       in/out     0x0 input_offset_uv, 0x4 amplifier_gain_q8
//
//  one request takes two passes of the shared 32-step divider (one when the
//  voltage lands on the last table point), a log2(points) step table search
//  and the setup states; zero gain or an out of range voltage ends early.
//  s_axis_tready is high only while the sequencer is idle; a finished result
//  waits in the output register while the next request is taken.
//  reset clears the sequencer, output valid and the registers (gain 1.0).
// ----------------------------------------------------------------------------
module thermocouple_k_table_interpolate
    import tkti_pkg::*;
#(
    parameter int TABLE_POINTS     = DEF_TABLE_POINTS,
    parameter int DEGREES_PER_STEP = DEF_DEGREES_PER_STEP
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [22:0] measured_uv, [23] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] temperature_centi_c
    output logic [0:0]  m_axis_tuser,   // [0] out_of_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tkti_cfg_t     cfg;
    tkti_div_req_t div_req;
    tkti_div_rsp_t div_rsp;
    logic          oor;

    // configuration registers
    tkti_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // shared divider
    tkti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer and result register
    tkti_seq #(
        .TABLE_POINTS     (TABLE_POINTS),
        .DEGREES_PER_STEP (DEGREES_PER_STEP)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_meas   (s_axis_tdata[MEAS_W-1:0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_temp  (m_axis_tdata),
        .out_oor   (oor),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    assign m_axis_tuser = oor;

endmodule
